FILE: hdl/utre_pkg.sv
// Shared types, codes and constants for the tablet report engine.
package utre_pkg;

	// Motion accumulator width and the width of one saturating sum
	localparam int ACC_WIDTH = 16;
	localparam int DELTA_WIDTH = 16;
	localparam int SUM_WIDTH = ((ACC_WIDTH > DELTA_WIDTH) ? ACC_WIDTH : DELTA_WIDTH) + 1;

	// Pen scaling: position times full scale, divided by the host span 2^15 - 1
	localparam int ABS_WIDTH = 15;
	localparam int MAX_WIDTH = 16;
	localparam int PROD_WIDTH = ABS_WIDTH + MAX_WIDTH;
	localparam int DIV_SHIFT = 15;
	localparam int QEST_WIDTH = PROD_WIDTH - DIV_SHIFT + 1;
	localparam int THR_WIDTH = PROD_WIDTH + 2;
	localparam logic [THR_WIDTH-1:0] HOST_SPAN = THR_WIDTH'(32'h7FFF);

	// Reply descriptor sizing
	localparam int REPLY_BYTES = 7;
	localparam int CNT_WIDTH = 3;

	// Descriptor queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	// Configuration registers
	localparam int CFG_IDX_WIDTH = 1;
	localparam logic [MAX_WIDTH-1:0] X_MAX_RESET = 16'd5040;
	localparam logic [MAX_WIDTH-1:0] Y_MAX_RESET = 16'd3780;

	// Report modes and report byte constants
	localparam logic [7:0] MODE_MOUSE = 8'd1;
	localparam logic [7:0] MODE_TABLET = 8'd2;
	localparam logic [7:0] PRESSURE_UP = 8'h81;
	localparam logic [6:0] MOUSE_WHEEL_LEN = 7'd4;
	localparam logic [6:0] TABLET_LEN = 7'd7;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_X_MAX = 1'b0,
		CFG_Y_MAX = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_MOVE       = 4'd0,
		OP_PEN        = 4'd1,
		OP_INT_POLL   = 4'd2,
		OP_GET_REPORT = 4'd3,
		OP_SET_MODE   = 4'd4,
		OP_GET_MODE   = 4'd5,
		OP_SET_IDLE   = 4'd6,
		OP_GET_IDLE   = 4'd7,
		OP_BUS_RESET  = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_DATA = 2'd0,
		ST_NAK  = 2'd1,
		ST_ZLP  = 2'd2,
		ST_ACK  = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0]                    op;
		logic signed [DELTA_WIDTH-1:0] delta_x;
		logic signed [DELTA_WIDTH-1:0] delta_y;
		logic signed [DELTA_WIDTH-1:0] delta_z;
		logic [ABS_WIDTH-1:0]          abs_x;
		logic [ABS_WIDTH-1:0]          abs_y;
		logic [2:0]                    buttons;
		logic [6:0]                    request_len;
		logic [7:0]                    value_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	// One request's whole reply: shared status, byte count, bytes in send order
	typedef struct packed {
		status_t                         status;
		logic [CNT_WIDTH-1:0]            count;
		logic [REPLY_BYTES-1:0][7:0]     bytes;
	} reply_t;

endpackage

FILE: hdl/utre_front.sv
// Front end: accepts requests, scales pen positions, updates state, builds replies.
module utre_front import utre_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [MAX_WIDTH-1:0]     cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     push,
	output reply_t                   push_data,
	input  logic                     q_full
);

	// Saturating add of a signed delta into an accumulator
	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0]   a,
		input logic signed [DELTA_WIDTH-1:0] d
	);
		logic signed [SUM_WIDTH-1:0] s;
		logic signed [SUM_WIDTH-1:0] hi;
		logic signed [SUM_WIDTH-1:0] lo;
		hi = {{(SUM_WIDTH-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
		lo = ~hi;
		s = SUM_WIDTH'(a) + SUM_WIDTH'(d);
		if (s > hi) begin
			return ACC_WIDTH'(hi);
		end else if (s < lo) begin
			return ACC_WIDTH'(lo);
		end
		return ACC_WIDTH'(s);
	endfunction

	// Clamp an accumulator to -128..127
	function automatic logic [7:0] clamp8(input logic signed [ACC_WIDTH-1:0] a);
		logic fits;
		fits = (a[ACC_WIDTH-1:7] == '0) || (a[ACC_WIDTH-1:7] == '1);
		if (fits) begin
			return a[7:0];
		end
		return a[ACC_WIDTH-1] ? 8'h80 : 8'h7F;
	endfunction

	logic [MAX_WIDTH-1:0] x_max_q, y_max_q;

	logic en;
	logic v_s1, v_s2, v_s3;
	in_item_t item_s1, item_s2, item_s3;
	logic [PROD_WIDTH-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic [QEST_WIDTH-1:0] qx_s3, qy_s3;

	logic signed [ACC_WIDTH-1:0] acc_dx_q, acc_dy_q, acc_dz_q;
	logic signed [ACC_WIDTH-1:0] acc_dx_d, acc_dy_d, acc_dz_d;
	logic [MAX_WIDTH-1:0] pen_x_q, pen_y_q, pen_x_d, pen_y_d;
	logic [2:0] held_q, held_d;
	logic [7:0] mode_q, mode_d, idle_q, idle_d;
	logic changed_q, changed_d;

	logic [THR_WIDTH-1:0] thr_x, thr_y;
	logic [MAX_WIDTH-1:0] pen_x_new, pen_y_new;
	logic [7:0] vx, vy, vz;
	logic do_report;
	reply_t rpt, reply;
	logic reply_ok;

	// Advance the whole pipeline unless the last stage cannot hand off
	assign en = !(v_s3 && q_full);
	assign in_stall = !en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_max_q <= X_MAX_RESET;
			y_max_q <= Y_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_MAX: x_max_q <= cfg_data;
				CFG_Y_MAX: y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 multiplies, stage 2 estimates the quotient by the host span
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_data;
			px_s1 <= PROD_WIDTH'(in_data.abs_x) * PROD_WIDTH'(x_max_q);
			py_s1 <= PROD_WIDTH'(in_data.abs_y) * PROD_WIDTH'(y_max_q);
			item_s2 <= item_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			item_s3 <= item_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			qx_s3 <= QEST_WIDTH'(((PROD_WIDTH+1)'(px_s2) + (PROD_WIDTH+1)'(px_s2 >> DIV_SHIFT))
				>> DIV_SHIFT);
			qy_s3 <= QEST_WIDTH'(((PROD_WIDTH+1)'(py_s2) + (PROD_WIDTH+1)'(py_s2 >> DIV_SHIFT))
				>> DIV_SHIFT);
		end
	end

	// Correct the estimate: it is low by at most one
	always_comb begin
		thr_x = (THR_WIDTH'(qx_s3) << DIV_SHIFT) - THR_WIDTH'(qx_s3) + HOST_SPAN;
		thr_y = (THR_WIDTH'(qy_s3) << DIV_SHIFT) - THR_WIDTH'(qy_s3) + HOST_SPAN;
		pen_x_new = (THR_WIDTH'(px_s3) >= thr_x) ? MAX_WIDTH'(qx_s3 + 1'b1) : MAX_WIDTH'(qx_s3);
		pen_y_new = (THR_WIDTH'(py_s3) >= thr_y) ? MAX_WIDTH'(qy_s3 + 1'b1) : MAX_WIDTH'(qy_s3);
	end

	// Build the poll report from current state
	always_comb begin
		vx = clamp8(acc_dx_q);
		vy = clamp8(acc_dy_q);
		vz = clamp8(acc_dz_q);
		rpt.status = ST_ZLP;
		rpt.count = CNT_WIDTH'(1);
		rpt.bytes = '0;
		if (mode_q == MODE_MOUSE) begin
			rpt.status = ST_DATA;
			rpt.count = (item_s3.request_len >= MOUSE_WHEEL_LEN) ? CNT_WIDTH'(4) : CNT_WIDTH'(3);
			rpt.bytes[0] = {5'b0, held_q};
			rpt.bytes[1] = vx;
			rpt.bytes[2] = vy;
			rpt.bytes[3] = vz;
		end else if (mode_q == MODE_TABLET && item_s3.request_len >= TABLET_LEN) begin
			rpt.status = ST_DATA;
			rpt.count = CNT_WIDTH'(REPLY_BYTES);
			rpt.bytes[0] = mode_q;
			rpt.bytes[1] = pen_x_q[7:0];
			rpt.bytes[2] = pen_x_q[15:8];
			rpt.bytes[3] = pen_y_q[7:0];
			rpt.bytes[4] = pen_y_q[15:8];
			rpt.bytes[5] = {1'b0, held_q[1], held_q[2], 5'b0};
			rpt.bytes[6] = (held_q[0] || held_q[2]) ? 8'h00 : PRESSURE_UP;
		end
	end

	// Execute the request in stage 3
	always_comb begin
		acc_dx_d = acc_dx_q;
		acc_dy_d = acc_dy_q;
		acc_dz_d = acc_dz_q;
		pen_x_d = pen_x_q;
		pen_y_d = pen_y_q;
		held_d = held_q;
		mode_d = mode_q;
		idle_d = idle_q;
		changed_d = changed_q;
		do_report = 1'b0;
		reply_ok = 1'b1;
		reply.status = ST_ACK;
		reply.count = CNT_WIDTH'(1);
		reply.bytes = '0;
		case (item_s3.op)
			OP_MOVE: begin
				acc_dx_d = sat_add(acc_dx_q, item_s3.delta_x);
				acc_dy_d = sat_add(acc_dy_q, item_s3.delta_y);
				acc_dz_d = sat_add(acc_dz_q, item_s3.delta_z);
				held_d = item_s3.buttons;
				changed_d = 1'b1;
			end
			OP_PEN: begin
				pen_x_d = pen_x_new;
				pen_y_d = pen_y_new;
				acc_dz_d = sat_add(acc_dz_q, item_s3.delta_z);
				held_d = item_s3.buttons;
				changed_d = 1'b1;
			end
			OP_INT_POLL: begin
				if (!changed_q && idle_q == 8'd0) begin
					reply.status = ST_NAK;
				end else begin
					changed_d = 1'b0;
					do_report = 1'b1;
				end
			end
			OP_GET_REPORT: do_report = 1'b1;
			OP_SET_MODE: mode_d = item_s3.value_byte;
			OP_GET_MODE: begin
				reply.status = ST_DATA;
				reply.count = CNT_WIDTH'(2);
				reply.bytes[1] = mode_q;
			end
			OP_SET_IDLE: idle_d = item_s3.value_byte;
			OP_GET_IDLE: begin
				reply.status = ST_DATA;
				reply.bytes[0] = idle_q;
			end
			OP_BUS_RESET: begin
				acc_dx_d = '0;
				acc_dy_d = '0;
				acc_dz_d = '0;
				pen_x_d = '0;
				pen_y_d = '0;
				held_d = '0;
				mode_d = MODE_MOUSE;
			end
			default: reply_ok = 1'b0;
		endcase
		// In mouse mode, take reported motion out of the accumulators
		if (do_report) begin
			reply = rpt;
			if (mode_q == MODE_MOUSE) begin
				acc_dx_d = acc_dx_q - ACC_WIDTH'(signed'(vx));
				acc_dy_d = acc_dy_q - ACC_WIDTH'(signed'(vy));
				acc_dz_d = acc_dz_q - ACC_WIDTH'(signed'(vz));
			end
		end
	end

	// Commit state when stage 3 hands off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_dx_q <= '0;
			acc_dy_q <= '0;
			acc_dz_q <= '0;
			pen_x_q <= '0;
			pen_y_q <= '0;
			held_q <= '0;
			mode_q <= MODE_MOUSE;
			idle_q <= '0;
			changed_q <= 1'b1;
		end else if (en && v_s3) begin
			acc_dx_q <= acc_dx_d;
			acc_dy_q <= acc_dy_d;
			acc_dz_q <= acc_dz_d;
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
			held_q <= held_d;
			mode_q <= mode_d;
			idle_q <= idle_d;
			changed_q <= changed_d;
		end
	end

	assign push = en && v_s3 && reply_ok;
	assign push_data = reply;

endmodule

FILE: hdl/utre_queue.sv
// Short reply descriptor queue between the front and back ends.
module utre_queue import utre_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  reply_t push_data,
	output logic   full,
	input  logic   pop,
	output reply_t head,
	output logic   empty
);

	reply_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0] cnt_q;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

endmodule

FILE: hdl/utre_back.sv
// Back end: sends replies one byte per cycle unless stalled.
module utre_back import utre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  reply_t    q_head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	reply_t cur_q;
	logic cur_valid_q;
	logic [CNT_WIDTH-1:0] idx_q;
	logic out_valid_q;
	out_item_t out_q;

	logic take, emit, is_last, done;

	assign take = !out_valid_q || !out_stall;
	assign emit = take && cur_valid_q;
	assign is_last = (idx_q == cur_q.count - CNT_WIDTH'(1));
	assign done = emit && is_last;
	assign pop = !q_empty && (!cur_valid_q || done);

	// Hold the descriptor being sent and step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q <= '0;
		end else if (done) begin
			cur_valid_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte <= cur_q.bytes[idx_q];
			out_q.status <= cur_q.status;
			out_q.last <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: hdl/usb_tablet_report_engine.sv
// Top level of the USB tablet report engine: front end, reply queue, back end.
//
//   port group   dir  handshake           payload
//   in_*         in   in_valid/in_stall   in_item_t  (op, deltas, pen position, ...)
//   out_*        out  out_valid/out_stall out_item_t (out_byte, status, last)
//   cfg_*        in   cfg_we              cfg_index, cfg_data (tablet x/y full scale)
//
// A request passes the front-end pipeline stages (multiply, quotient estimate,
// execute), and its reply of 1 to 7 bytes is then sent one byte per cycle while
// the output is not stalled; a request every cycle while such replies are one byte.
// Reset clears motion, pen position and buttons, selects mouse mode, sets the
// changed flag and loads the default full-scale values. A stalled output backs up
// the four-entry reply queue, and only then stalls the input.
module usb_tablet_report_engine import utre_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [MAX_WIDTH-1:0]     cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data
);

	logic push, pop, q_full, q_empty;
	reply_t push_data, q_head;

	utre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	utre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	utre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
